// ----- src/tcba_pkg.sv -----
// shared types and constants for the branch and alu step core
package tcba_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned RIDX_W  = 4;
  localparam int unsigned OUT_IDX_W = 3;
  localparam int unsigned PC_OUT_W  = 16;
  localparam int unsigned FLAG_W  = 6;
  localparam int unsigned OFS_W   = 27;

  // instruction word fields
  localparam int unsigned CODE_LSB = 28;
  localparam int unsigned SIGN_BIT = 27;
  localparam int unsigned IMMS_LSB = 24;
  localparam int unsigned OP_LSB   = 20;
  localparam int unsigned FO_LSB   = 16;
  localparam int unsigned SO_LSB   = 12;
  localparam int unsigned DR_LSB   = 8;
  localparam int unsigned IMM_W    = 8;

  // compare flag positions
  localparam int unsigned FLAG_EQ = 5;
  localparam int unsigned FLAG_NE = 4;
  localparam int unsigned FLAG_LE = 3;
  localparam int unsigned FLAG_GE = 2;
  localparam int unsigned FLAG_LT = 1;
  localparam int unsigned FLAG_GT = 0;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_ORR = 4'd1,
    OP_EOR = 4'd2,
    OP_ADD = 4'd3,
    OP_ADC = 4'd4,
    OP_CMP = 4'd5,
    OP_SUB = 4'd6,
    OP_SBC = 4'd7,
    OP_MOV = 4'd8,
    OP_LSH = 4'd9,
    OP_RSH = 4'd10
  } op_e;

  typedef enum logic [3:0] {
    BR_B   = 4'd8,
    BR_BEQ = 4'd9,
    BR_BNE = 4'd10,
    BR_BLE = 4'd11,
    BR_BGE = 4'd12,
    BR_BL  = 4'd13,
    BR_BG  = 4'd14
  } br_e;

  typedef struct packed {
    logic                 carry_out;
    logic [FLAG_W-1:0]    cmp_flags;
    logic [DATA_W-1:0]    dest_value;
    logic [OUT_IDX_W-1:0] dest_index;
    logic                 reg_written;
    logic                 branch_taken;
    logic [PC_OUT_W-1:0]  next_pc;
  } res_t;

endpackage

// ----- src/tiny_core_branch_and_alu_step.sv -----
// top level: input register, register file, execute logic and result register
//
//  channel  | dir | handshake              | payload
//  s_axis   | in  | tvalid / tready        | tuser action, tdata instruction and load
//  m_axis   | out | tvalid / tready        | tdata pc, flags, carry and write-back
//
// one transaction per cycle while the result register is not stalled; execution runs while it
// sits in the input register, and its result is then loaded into the result register
// register operands are read at input accept and bypassed from the write in flight
// reset clears the register file through valid bits, plus pc, carry and flags
// a stalled result holds the execute stage; input is still taken while it is empty
module tiny_core_branch_and_alu_step import tcba_pkg::*; #(
  parameter int unsigned PC_BITS        = 16,
  parameter int unsigned REGISTER_COUNT = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // instr_word[31:0], load_index[34:32], load_value[98:35], zero fill
  input  logic [103:0] s_axis_tdata_i,
  // action[0]
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // next_pc[15:0], branch_taken[16], reg_written[17], dest_index[20:18],
  // dest_value[84:21], cmp_flags[90:85], carry_out[91], zero fill
  output logic [95:0]  m_axis_tdata_o
);

  localparam int unsigned IDX_W = $clog2(REGISTER_COUNT);

  logic                 in_valid_q, in_valid_d;
  logic                 action_q;
  logic [WORD_W-1:0]    instr_q;
  logic [OUT_IDX_W-1:0] lidx_q;
  logic [DATA_W-1:0]    lval_q;
  logic                 out_valid_q, out_valid_d;
  res_t                 res_q, res;
  logic [PC_BITS-1:0]   pc_q, pc_d;
  logic                 carry_q;
  logic [FLAG_W-1:0]    flags_q;
  logic                 advance, exec_en, accept;
  logic [DATA_W-1:0]    op_a, op_b;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign exec_en         = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (exec_en) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (exec_en) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      carry_q     <= 1'b0;
      flags_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (exec_en) begin
        pc_q    <= pc_d;
        carry_q <= res.carry_out;
        flags_q <= res.cmp_flags;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= s_axis_tuser_i;
      instr_q  <= s_axis_tdata_i[31:0];
      lidx_q   <= s_axis_tdata_i[34:32];
      lval_q   <= s_axis_tdata_i[98:35];
    end
    if (exec_en) begin
      res_q <= res;
    end
  end

  tcba_regfile #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_a_i(s_axis_tdata_i[FO_LSB +: RIDX_W]),
    .rd_addr_b_i(s_axis_tdata_i[SO_LSB +: RIDX_W]),
    .wr_en_i    (exec_en && wr_en),
    .wr_idx_i   (wr_idx),
    .wr_data_i  (res.dest_value),
    .rd_data_a_o(op_a),
    .rd_data_b_o(op_b)
  );

  tcba_exec #(
    .PC_BITS       (PC_BITS),
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_exec (
    .action_i    (action_q),
    .instr_i     (instr_q),
    .load_index_i(lidx_q),
    .load_value_i(lval_q),
    .op_a_i      (op_a),
    .op_b_reg_i  (op_b),
    .pc_i        (pc_q),
    .carry_i     (carry_q),
    .flags_i     (flags_q),
    .pc_o        (pc_d),
    .wr_en_o     (wr_en),
    .wr_idx_o    (wr_idx),
    .res_o       (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, res_q};

`ifndef NO_ASSERTIONS
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready_o)
    else $error("input stage empty but not ready");

  a_exec_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_en |=> m_axis_tvalid_o)
    else $error("executed transaction did not reach result register");

  a_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec_en |=> $stable(pc_q) && $stable(carry_q) && $stable(flags_q))
    else $error("architectural state changed without execution");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !res_q.reg_written) |-> (res_q.dest_value == '0))
    else $error("dest value nonzero without register write");
`endif

endmodule

// ----- src/tcba_regfile.sv -----
// register file with per-entry valid bits, registered reads and write bypass
module tcba_regfile import tcba_pkg::*; #(
  parameter int unsigned REGISTER_COUNT = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,
  input  logic [RIDX_W-1:0]                    rd_addr_a_i,
  input  logic [RIDX_W-1:0]                    rd_addr_b_i,
  input  logic                                 wr_en_i,
  input  logic [$clog2(REGISTER_COUNT)-1:0]    wr_idx_i,
  input  logic [DATA_W-1:0]                    wr_data_i,
  output logic [DATA_W-1:0]                    rd_data_a_o,
  output logic [DATA_W-1:0]                    rd_data_b_o
);

  localparam int unsigned IDX_W = $clog2(REGISTER_COUNT);
  localparam int unsigned CNT_W = $clog2(REGISTER_COUNT + 1);

  logic [DATA_W-1:0]         mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] valid_q;
  logic [DATA_W-1:0]         data_a_q, data_b_q;
  logic                      zero_a_q, zero_b_q;
  logic [IDX_W-1:0]          idx_a, idx_b;
  logic                      in_a, in_b, hit_a, hit_b;

  assign idx_a = rd_addr_a_i[IDX_W-1:0];
  assign idx_b = rd_addr_b_i[IDX_W-1:0];
  assign in_a  = CNT_W'(rd_addr_a_i) < CNT_W'(REGISTER_COUNT);
  assign in_b  = CNT_W'(rd_addr_b_i) < CNT_W'(REGISTER_COUNT);
  assign hit_a = wr_en_i && (wr_idx_i == idx_a);
  assign hit_b = wr_en_i && (wr_idx_i == idx_b);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_a_q <= hit_a ? wr_data_i : mem[idx_a];
      data_b_q <= hit_b ? wr_data_i : mem[idx_b];
      zero_a_q <= !in_a || (!hit_a && !valid_q[idx_a]);
      zero_b_q <= !in_b || (!hit_b && !valid_q[idx_b]);
    end
  end

  assign rd_data_a_o = zero_a_q ? '0 : data_a_q;
  assign rd_data_b_o = zero_b_q ? '0 : data_b_q;

endmodule

// ----- src/tcba_exec.sv -----
// branch resolution, alu and write-back decode for one transaction
module tcba_exec import tcba_pkg::*; #(
  parameter int unsigned PC_BITS        = 16,
  parameter int unsigned REGISTER_COUNT = 8
) (
  input  logic                              action_i,
  input  logic [WORD_W-1:0]                 instr_i,
  input  logic [OUT_IDX_W-1:0]              load_index_i,
  input  logic [DATA_W-1:0]                 load_value_i,
  input  logic [DATA_W-1:0]                 op_a_i,
  input  logic [DATA_W-1:0]                 op_b_reg_i,
  input  logic [PC_BITS-1:0]                pc_i,
  input  logic                              carry_i,
  input  logic [FLAG_W-1:0]                 flags_i,
  output logic [PC_BITS-1:0]                pc_o,
  output logic                              wr_en_o,
  output logic [$clog2(REGISTER_COUNT)-1:0] wr_idx_o,
  output res_t                              res_o
);

  localparam int unsigned IDX_W = $clog2(REGISTER_COUNT);
  localparam int unsigned CNT_W = $clog2(REGISTER_COUNT + 1);
  localparam int unsigned OW    = (PC_BITS > OFS_W) ? PC_BITS : OFS_W;

  logic [3:0]        code, imms, dr;
  op_e               op;
  logic [DATA_W-1:0] b;
  logic [DATA_W:0]   sum, diff;
  logic              cin, bin, big;
  logic              is_branch, cond;
  logic [OW-1:0]     pc_ext, mag_ext, target;
  logic [31:0]       pc_wide;
  logic [DATA_W-1:0] r;
  logic              wr, carry_n;
  logic [FLAG_W-1:0] flags_n;
  logic [RIDX_W-1:0] didx;
  logic [DATA_W-1:0] dval;

  assign code = instr_i[CODE_LSB +: 4];
  assign imms = instr_i[IMMS_LSB +: 4];
  assign op   = op_e'(instr_i[OP_LSB +: 4]);
  assign dr   = instr_i[DR_LSB +: 4];
  assign b    = (imms != 4'd0) ? DATA_W'(instr_i[IMM_W-1:0]) : op_b_reg_i;

  assign cin  = (op == OP_ADC) ? carry_i : 1'b0;
  assign bin  = (op == OP_SBC) ? !carry_i : 1'b0;
  assign sum  = {1'b0, op_a_i} + {1'b0, b} + (DATA_W+1)'(cin);
  assign diff = {1'b0, op_a_i} - {1'b0, b} - (DATA_W+1)'(bin);
  assign big  = |b[DATA_W-1:6];

  assign is_branch = (code inside {[BR_B:BR_BG]});
  assign pc_ext    = OW'(pc_i);
  assign mag_ext   = OW'(instr_i[OFS_W-1:0]);
  assign target    = instr_i[SIGN_BIT] ? (pc_ext - mag_ext) : (pc_ext + mag_ext);

  always_comb begin
    unique case (code)
      BR_B:    cond = 1'b1;
      BR_BEQ:  cond = flags_i[FLAG_EQ];
      BR_BNE:  cond = flags_i[FLAG_NE];
      BR_BLE:  cond = flags_i[FLAG_LE];
      BR_BGE:  cond = flags_i[FLAG_GE];
      BR_BL:   cond = flags_i[FLAG_LT];
      BR_BG:   cond = flags_i[FLAG_GT];
      default: cond = 1'b0;
    endcase
  end

  always_comb begin
    r       = '0;
    wr      = 1'b1;
    carry_n = carry_i;
    flags_n = flags_i;
    unique case (op)
      OP_AND: r = op_a_i & b;
      OP_ORR: r = op_a_i | b;
      OP_EOR: r = op_a_i ^ b;
      OP_ADD, OP_ADC: begin
        r       = sum[DATA_W-1:0];
        carry_n = sum[DATA_W];
      end
      OP_CMP: begin
        wr               = 1'b0;
        flags_n[FLAG_EQ] = (op_a_i == b);
        flags_n[FLAG_NE] = (op_a_i != b);
        flags_n[FLAG_LE] = (op_a_i <= b);
        flags_n[FLAG_GE] = (op_a_i >= b);
        flags_n[FLAG_LT] = (op_a_i < b);
        flags_n[FLAG_GT] = (op_a_i > b);
      end
      OP_SUB, OP_SBC: begin
        r       = diff[DATA_W-1:0];
        carry_n = diff[DATA_W];
      end
      OP_MOV: r = b;
      OP_LSH: r = big ? '0 : (op_a_i << b[5:0]);
      OP_RSH: r = big ? '0 : (op_a_i >> b[5:0]);
      default: wr = 1'b0;
    endcase
  end

  always_comb begin
    pc_o    = pc_i;
    wr_en_o = 1'b0;
    didx    = '0;
    dval    = '0;
    res_o   = '0;
    res_o.cmp_flags = flags_i;
    res_o.carry_out = carry_i;
    if (action_i) begin
      wr_en_o = 1'b1;
      didx    = RIDX_W'(load_index_i);
      dval    = load_value_i;
    end else if (is_branch) begin
      if (cond) begin
        pc_o               = target[PC_BITS-1:0];
        res_o.branch_taken = 1'b1;
      end else begin
        pc_o = pc_i + PC_BITS'(1);
      end
    end else begin
      pc_o            = pc_i + PC_BITS'(1);
      res_o.cmp_flags = flags_n;
      res_o.carry_out = carry_n;
      if (wr && (CNT_W'(dr) < CNT_W'(REGISTER_COUNT))) begin
        wr_en_o = 1'b1;
        didx    = dr;
        dval    = r;
      end
    end
    res_o.reg_written = wr_en_o;
    res_o.dest_index  = didx[OUT_IDX_W-1:0];
    res_o.dest_value  = dval;
    res_o.next_pc     = pc_wide[PC_OUT_W-1:0];
  end

  assign pc_wide  = 32'(pc_o);
  assign wr_idx_o = didx[IDX_W-1:0];

endmodule
